// ===== design/prsd_pkg.sv =====
package prsd_pkg;

   localparam logic [15:0] DAMPING_RESET = 16'd55706;
   localparam int          INDEX_W       = 12;
   localparam int          RANK_W        = 32;
   localparam int          SUM_W         = 48;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_EDGE    = 2'd1,
      OP_END_ROW = 2'd2,
      OP_SWAP    = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [INDEX_W-1:0] index;
      logic [RANK_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] row;
      logic [RANK_W-1:0]  rank_new;
      logic [SUM_W-1:0]   error_sum;
   } rsp_type;

   // item after the front end has decoded it
   typedef struct packed {
      op_type             op;
      logic               idx_ok;
      logic [INDEX_W-1:0] index;
      logic [RANK_W-1:0]  value;
   } cmd_type;

endpackage

// ===== design/prsd_ram.sv =====
module prsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/prsd_front.sv =====
module prsd_front
   import prsd_pkg::*;
#(
   parameter int VERTICES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_take
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept;
   logic       take;
   cmd_type    decoded;

   assign full   = (cnt_ff == 2'd2);
   assign accept = push && !full;
   assign take   = cmd_take && cmd_valid;

   always_comb begin
      decoded.op     = op_type'(req_item.op);
      decoded.idx_ok = (32'(req_item.index) < 32'(VERTICES));
      decoded.index  = req_item.index;
      decoded.value  = req_item.value;
   end

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      case ({accept, take})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

endmodule

// ===== design/prsd_back.sv =====
module prsd_back
   import prsd_pkg::*;
#(
   parameter int VERTICES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] damping,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_take,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_item
);

   localparam int AW = $clog2(VERTICES);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_EDGE_MUL = 7'b0000010,
      ST_EDGE_ACC = 7'b0000100,
      ST_ROW_MUL  = 7'b0001000,
      ST_ROW_SUM  = 7'b0010000,
      ST_ROW_DIFF = 7'b0100000,
      ST_ROW_OUT  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff;
   logic              bank_sel_ff, bank_sel_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]  err_ff, err_in;
   logic [63:0]       prod_ff;
   logic [39:0]       pa_ff, pb_ff;
   logic [48:0]       pc_ff;
   logic [64:0]       mix_ff;
   logic [RANK_W-1:0] old_ff, fresh_ff, diff_ff;

   logic [RANK_W-1:0] rd_a, rd_b, cur_rd;
   logic              wa_en, wb_en;
   logic [AW-1:0]     waddr;
   logic [RANK_W-1:0] wdata;
   logic [SUM_W:0]    acc_sum, err_sum;
   logic [48:0]       mix_hi;
   logic [RANK_W-1:0] fresh;
   logic [SUM_W-1:0]  err_next;

   rsp_type    res_q_ff [2];
   logic       res_wptr_ff, res_rptr_ff;
   logic [1:0] res_cnt_ff, res_cnt_in;
   logic       res_push, res_pop;

   assign cmd_take = (state_ff == ST_IDLE) && cmd_valid;
   assign res_push = (state_ff == ST_ROW_OUT) && (res_cnt_ff != 2'd2);
   assign res_pop  = pop && !empty;

   prsd_ram #(.WIDTH(RANK_W), .DEPTH(VERTICES)) u_bank_a (
      .clock (clock),
      .we    (wa_en),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (AW'(cmd.index)),
      .rdata (rd_a)
   );

   prsd_ram #(.WIDTH(RANK_W), .DEPTH(VERTICES)) u_bank_b (
      .clock (clock),
      .we    (wb_en),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (AW'(cmd.index)),
      .rdata (rd_b)
   );

   // out-of-range vertex reads as zero
   assign cur_rd = cmd_ff.idx_ok ? (bank_sel_ff ? rd_b : rd_a) : '0;

   always_comb begin
      wa_en = 1'b0;
      wb_en = 1'b0;
      waddr = AW'(cmd.index);
      wdata = cmd.value;
      if (cmd_take && cmd.op == OP_LOAD && cmd.idx_ok) begin
         wa_en = !bank_sel_ff;
         wb_en = bank_sel_ff;
      end
      if (res_push && cmd_ff.idx_ok) begin
         // new rank goes to the non-current bank
         waddr = AW'(cmd_ff.index);
         wdata = fresh_ff;
         wa_en = bank_sel_ff;
         wb_en = !bank_sel_ff;
      end
   end

   always_comb begin
      acc_sum  = (SUM_W+1)'(acc_ff) + (SUM_W+1)'(prod_ff[63:31]);
      mix_hi   = mix_ff[64:16];
      fresh    = (|mix_hi[48:32]) ? '1 : mix_hi[31:0];
      err_sum  = (SUM_W+1)'(err_ff) + (SUM_W+1)'(diff_ff);
      err_next = err_sum[SUM_W] ? '1 : err_sum[SUM_W-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      bank_sel_in = bank_sel_ff;
      acc_in      = acc_ff;
      err_in      = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_take) begin
               case (cmd.op)
                  OP_EDGE:    state_in = ST_EDGE_MUL;
                  OP_END_ROW: state_in = ST_ROW_MUL;
                  OP_SWAP: begin
                     bank_sel_in = !bank_sel_ff;
                     err_in      = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_EDGE_MUL: state_in = ST_EDGE_ACC;
         ST_EDGE_ACC: begin
            acc_in   = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
            state_in = ST_IDLE;
         end
         ST_ROW_MUL:  state_in = ST_ROW_SUM;
         ST_ROW_SUM:  state_in = ST_ROW_DIFF;
         ST_ROW_DIFF: state_in = ST_ROW_OUT;
         ST_ROW_OUT: begin
            if (res_push) begin
               err_in   = err_next;
               acc_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bank_sel_ff <= 1'b0;
         acc_ff      <= '0;
         err_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         bank_sel_ff <= bank_sel_in;
         acc_ff      <= acc_in;
         err_ff      <= err_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd_take) begin
         cmd_ff <= cmd;
      end
      if (state_ff == ST_EDGE_MUL) begin
         prod_ff <= 64'(cmd_ff.value) * 64'(cur_rd);
      end
      if (state_ff == ST_ROW_MUL) begin
         old_ff <= cur_rd;
         pa_ff  <= 40'(damping) * 40'(acc_ff[23:0]);
         pb_ff  <= 40'(damping) * 40'(acc_ff[47:24]);
         pc_ff  <= 49'(17'h10000 - {1'b0, damping}) * 49'(cmd_ff.value);
      end
      if (state_ff == ST_ROW_SUM) begin
         mix_ff <= 65'({pb_ff, 24'b0}) + 65'(pa_ff) + 65'(pc_ff);
      end
      if (state_ff == ST_ROW_DIFF) begin
         fresh_ff <= fresh;
         diff_ff  <= (fresh >= old_ff) ? fresh - old_ff : old_ff - fresh;
      end
   end

   // result queue
   always_comb begin
      case ({res_push, res_pop})
         2'b10:   res_cnt_in = res_cnt_ff + 2'd1;
         2'b01:   res_cnt_in = res_cnt_ff - 2'd1;
         default: res_cnt_in = res_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wptr_ff <= 1'b0;
         res_rptr_ff <= 1'b0;
         res_cnt_ff  <= 2'd0;
      end else begin
         res_wptr_ff <= res_push ? !res_wptr_ff : res_wptr_ff;
         res_rptr_ff <= res_pop ? !res_rptr_ff : res_rptr_ff;
         res_cnt_ff  <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_q_ff[res_wptr_ff] <= '{row: cmd_ff.index, rank_new: fresh_ff,
                                    error_sum: err_next};
      end
   end

   assign empty    = (res_cnt_ff == 2'd0);
   assign rsp_item = res_q_ff[res_rptr_ff];

   a_err_grows: assert property (@(posedge clock) disable iff (reset)
      !(cmd_take && cmd.op == OP_SWAP) |=> err_ff >= $past(err_ff))
      else $error("error sum dropped without a swap");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      res_push |=> acc_ff == '0)
      else $error("row sum not cleared after end of row");

   a_push_from_row: assert property (@(posedge clock) disable iff (reset)
      res_push |-> cmd_ff.op == OP_END_ROW)
      else $error("result beat from an item that is not an end of row");

   a_res_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff != 2'd3)
      else $error("result queue overflow");

endmodule

// ===== design/pagerank_spmv_damping_step.sv =====
// Flow: items reach the engine through a 2-entry command queue; load and swap complete
//   in the idle state, and an end of row delivers its result once the result queue has room.
// Steps: edge is bank read, 32x32 multiply, saturating add; end of row is read,
//   three narrow multiplies, sum, clamp/diff, commit; no new item is taken until idle.
// Reset: queues empty, bank a current, row and error sums zero, damping 55706;
//   rank bank contents stay undefined until loaded (no clearing pass).
module pagerank_spmv_damping_step
   import prsd_pkg::*;
#(
   parameter int VERTICES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_item,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_item,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0] damping_ff, damping_in;
   logic        cmd_valid;
   cmd_type     cmd;
   logic        cmd_take;

   assign damping_in = csr_we ? csr_wdata : damping_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= DAMPING_RESET;
      end else begin
         damping_ff <= damping_in;
      end
   end

   prsd_front #(.VERTICES(VERTICES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   prsd_back #(.VERTICES(VERTICES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .damping   (damping_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== sim/tb_pagerank_spmv_damping_step.sv =====
module tb_pagerank_spmv_damping_step;
   import prsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // bank spans the whole 12-bit index space
   localparam int NUM_VERTS   = 4096;
   localparam int DRAIN_WAIT  = 16;
   localparam int LONG_HOLD   = 600;
   localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 64'd1;
   localparam logic [63:0] RANK_MAX = 64'hFFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   req_type     req_item = '0;
   logic        empty;
   logic        pop = 1'b0;
   rsp_type     rsp_item;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   // items waiting to be offered, results still owed by the block
   req_type     cmd_backlog[$];
   rsp_type     rank_results_due[$];
   int          err_cnt = 0;

   // shadow of the block's state
   logic [31:0] rank_mem [0:1][0:NUM_VERTS-1];
   bit          cur_bank = 1'b0;
   logic [63:0] row_sum = '0;
   logic [63:0] err_sum = '0;
   logic [15:0] damping_cfg = DAMPING_RESET;

   // generator-side view of which rank entries hold data
   bit          gen_written [0:1][0:NUM_VERTS-1];
   bit          gen_bank = 1'b0;
   int          gen_count = 0;

   bit          quiet = 1'b0;
   bit          long_stall_req = 1'b0;
   bit          stall_done = 1'b0;
   int          snd_gap = 0;
   int          rcv_gap = 0;
   int          hold_left = 0;

   always #6 clock = ~clock;

   pagerank_spmv_damping_step #(
      .VERTICES(NUM_VERTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_item(req_item),
      .empty(empty),
      .pop(pop),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   function automatic logic [63:0] add_sat48(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > SUM_MAX) ? SUM_MAX : s;
   endfunction

   function automatic logic [63:0] current_rank(input logic [INDEX_W-1:0] idx);
      if (idx >= NUM_VERTS) return 64'd0;
      return 64'(rank_mem[cur_bank][idx]);
   endfunction

   task automatic compute_rank_update(input req_type c);
      logic [63:0] prod;
      logic [63:0] mix;
      logic [63:0] fresh;
      logic [63:0] old;
      logic [63:0] diff;
      rsp_type     r;
      case (c.op)
         OP_LOAD: begin
            if (c.index < NUM_VERTS) rank_mem[cur_bank][c.index] = c.value;
         end
         OP_EDGE: begin
            prod = (64'(c.value) * current_rank(c.index)) >> 31;
            row_sum = add_sat48(row_sum, prod);
         end
         OP_END_ROW: begin
            mix = 64'(damping_cfg) * row_sum
                + (64'd65536 - 64'(damping_cfg)) * 64'(c.value);
            fresh = mix >> 16;
            if (fresh > RANK_MAX) fresh = RANK_MAX;
            old = current_rank(c.index);
            diff = (fresh >= old) ? fresh - old : old - fresh;
            err_sum = add_sat48(err_sum, diff);
            if (c.index < NUM_VERTS) rank_mem[~cur_bank][c.index] = fresh[31:0];
            row_sum = '0;
            r.row = c.index;
            r.rank_new = fresh[31:0];
            r.error_sum = err_sum[SUM_W-1:0];
            rank_results_due.push_back(r);
         end
         default: begin
            cur_bank = ~cur_bank;
            err_sum = '0;
         end
      endcase
   endtask

   // sender: one beat offered at a time, held until taken
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         snd_gap <= 0;
      end else begin
         if (push && !full) begin
            compute_rank_update(req_item);
            void'(cmd_backlog.pop_front());
         end
         if (push && full) begin
            // keep offering the same beat
         end else if (snd_gap != 0) begin
            push <= 1'b0;
            snd_gap <= snd_gap - 1;
         end else if (cmd_backlog.size() != 0 && !quiet && $urandom_range(0, 15) == 0) begin
            push <= 1'b0;
            snd_gap <= $urandom_range(0, 18);
         end else if (cmd_backlog.size() != 0) begin
            push <= 1'b1;
            req_item <= cmd_backlog[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver: checks each result beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         rcv_gap <= 0;
         hold_left <= 0;
      end else begin
         if (pop && !empty) begin
            if (rank_results_due.size() == 0) begin
               $display("%0t: result beat with nothing pending, row %0d rank %h err %h",
                        $time, rsp_item.row, rsp_item.rank_new, rsp_item.error_sum);
               err_cnt++;
            end else begin
               if (rsp_item.row !== rank_results_due[0].row) begin
                  $display("%0t: row expected %0d, got %0d",
                           $time, rank_results_due[0].row, rsp_item.row);
                  err_cnt++;
               end
               if (rsp_item.rank_new !== rank_results_due[0].rank_new) begin
                  $display("%0t: rank_new (row %0d) expected %h, got %h", $time,
                           rank_results_due[0].row, rank_results_due[0].rank_new,
                           rsp_item.rank_new);
                  err_cnt++;
               end
               if (rsp_item.error_sum !== rank_results_due[0].error_sum) begin
                  $display("%0t: error_sum (row %0d) expected %h, got %h", $time,
                           rank_results_due[0].row, rank_results_due[0].error_sum,
                           rsp_item.error_sum);
                  err_cnt++;
               end
               void'(rank_results_due.pop_front());
            end
         end
         if (long_stall_req && !stall_done) begin
            stall_done <= 1'b1;
            hold_left <= LONG_HOLD;
            pop <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
         end else if (rcv_gap != 0) begin
            rcv_gap <= rcv_gap - 1;
            pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            pop <= 1'b0;
            rcv_gap <= $urandom_range(0, 18);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(0, 255));
         3: return 32'h8000_0000 - 32'($urandom_range(0, 4096));
         default: return $urandom();
      endcase
   endfunction

   function automatic int pick_index();
      case ($urandom_range(0, 15))
         0: return 0;
         1: return 4095;
         2, 3: return $urandom_range(NUM_VERTS - 64, NUM_VERTS - 1);
         default: return $urandom_range(0, NUM_VERTS - 1);
      endcase
   endfunction

   task automatic put_cmd(input op_type op, input int idx, input logic [31:0] val);
      req_type r;
      r.op = op;
      r.index = idx[INDEX_W-1:0];
      r.value = val;
      if (idx < NUM_VERTS && op == OP_LOAD) gen_written[gen_bank][idx] = 1'b1;
      if (idx < NUM_VERTS && op == OP_END_ROW) gen_written[~gen_bank][idx] = 1'b1;
      if (op == OP_SWAP) gen_bank = ~gen_bank;
      cmd_backlog.push_back(r);
      gen_count++;
   endtask

   // never let the block read a rank entry that holds no data
   task automatic need_rank(input int idx);
      if (idx < NUM_VERTS && !gen_written[gen_bank][idx])
         put_cmd(OP_LOAD, idx, rand_word());
   endtask

   task automatic put_edge(input int idx, input logic [31:0] w);
      need_rank(idx);
      put_cmd(OP_EDGE, idx, w);
   endtask

   task automatic put_end_row(input int idx, input logic [31:0] prior);
      need_rank(idx);
      put_cmd(OP_END_ROW, idx, prior);
   endtask

   task automatic put_noise();
      int idx;
      idx = pick_index();
      case ($urandom_range(0, 3))
         0: put_cmd(OP_LOAD, idx, rand_word());
         1: put_edge(idx, rand_word());
         2: put_end_row(idx, rand_word());
         default: put_cmd(OP_SWAP, idx, $urandom());
      endcase
   endtask

   // small graph: load ranks, then a few full sweeps of rows, each closed by a swap
   task automatic run_iterations();
      int verts[$];
      int nv;
      nv = $urandom_range(2, 10);
      repeat (nv) verts.push_back(pick_index());
      foreach (verts[i]) put_cmd(OP_LOAD, verts[i], rand_word());
      repeat ($urandom_range(1, 4)) begin
         foreach (verts[i]) begin
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(0, 14) == 0) put_noise();
               put_edge(verts[$urandom_range(0, nv - 1)], rand_word());
            end
            put_end_row(verts[i], rand_word());
         end
         put_cmd(OP_SWAP, pick_index(), $urandom());
      end
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || push || rank_results_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic random_phase(input int n_items);
      gen_count = 0;
      while (gen_count < n_items) begin
         if ($urandom_range(0, 5) == 0) put_noise();
         else run_iterations();
      end
      wait_drained();
   endtask

   task automatic write_damping(input logic [15:0] d);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      damping_cfg = d;
      @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset damping
      put_cmd(OP_LOAD, 0, 32'hFFFF_FFFF);
      put_cmd(OP_LOAD, 4095, 32'hDEAD_BEEF);       // top entry, overwritten below
      put_cmd(OP_LOAD, 1, 32'h0000_0000);
      put_cmd(OP_LOAD, 2, 32'h8000_0000);
      put_cmd(OP_LOAD, NUM_VERTS - 1, 32'h0000_0001);
      put_edge(0, 32'hFFFF_FFFF);
      put_edge(0, 32'hFFFF_FFFF);
      put_edge(NUM_VERTS - 1, 32'h0000_0001);
      put_end_row(0, 32'hFFFF_FFFF);               // new rank clamps
      put_edge(1, 32'hFFFF_FFFF);
      put_end_row(1, 32'h0000_0000);
      put_end_row(2, 32'h0000_0000);               // row with no edges
      put_edge(4095, 32'hFFFF_FFFF);               // top column
      put_end_row(4095, 32'h1234_5678);            // top row
      put_edge(2, 32'h8000_0000);
      put_cmd(OP_SWAP, 0, 32'h0000_0000);          // row sum carries across
      put_end_row(0, 32'hFFFF_FFFF);
      put_edge(1, 32'h7FFF_FFFF);
      put_end_row(1, 32'h8000_0000);
      put_cmd(OP_SWAP, 4095, 32'hFFFF_FFFF);
      put_edge(2, 32'hFFFF_FFFF);
      put_end_row(2, 32'h8000_0000);
      random_phase(240);

      write_damping(16'd0);
      random_phase(260);

      write_damping(16'hFFFF);
      long_stall_req = 1'b1;                       // receiver stops, input backs up
      random_phase(260);

      write_damping(16'h8000);
      random_phase(260);

      write_damping(16'($urandom()));
      random_phase(260);

      write_damping(16'd1);
      quiet = 1'b1;
      random_phase(260);

      if (err_cnt == 0) begin
         $display("** pagerank_spmv_damping_step: PASSED **");
      end else begin
         $display("** pagerank_spmv_damping_step: FAILED **");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("%0t: timeout, %0d results outstanding", $time, rank_results_due.size());
      $display("** pagerank_spmv_damping_step: FAILED **");
      $finish;
   end

endmodule
